// ===== rtl/imtu_pkg.sv =====
// Shared types and constants for the majority-vote Ising torus update unit.
// No dependencies; imported by every module of the block.
package imtu_pkg;

  localparam logic [1:0] OP_LOAD = 2'd0;
  localparam logic [1:0] OP_RUN  = 2'd1;
  localparam logic [1:0] OP_READ = 2'd2;

  localparam logic CFG_GRID_SIDE   = 1'b0;
  localparam logic CFG_SWEEP_COUNT = 1'b1;

  localparam logic [6:0] SIDE_RESET  = 7'd64;
  localparam logic [7:0] SWEEP_RESET = 8'd1;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_READ,
    ST_DRAIN
  } imtu_state_t;

  // Per-cycle control that the sequencer broadcasts to every cell.
  typedef struct packed {
    logic shift_en;  // a source bit enters the chain
    logic row_done;  // that bit completes a row: window moves down one row
    logic load_r;    // capture the new row of majority results
    logic shift_r;   // move the result row one cell toward the write end
  } imtu_ctrl_t;

endpackage

// ===== rtl/imtu_cell.sv =====
// One column cell: holds a three-row window of one column and one result bit.
// Depends on imtu_pkg for the control struct.
module imtu_cell
  import imtu_pkg::*;
(
  input  logic       clk,
  input  imtu_ctrl_t ctrl,
  input  logic       d_in,
  input  logic       nb_lo,
  input  logic       nb_hi,
  input  logic       r_in,
  output logic       d_out,
  output logic       m_out,
  output logic       r_out
);

  logic       u;
  logic       m;
  logic       d;
  logic       r;
  logic [2:0] ones;
  logic       maj;

  // The incoming bit d_in is the lower row of the window on the completing shift.
  assign ones = 3'(u) + 3'(m) + 3'(d_in) + 3'(nb_lo) + 3'(nb_hi);
  assign maj  = (ones >= 3'd3);

  always_ff @(posedge clk) begin
    if (ctrl.shift_en) begin
      d <= d_in;
      if (ctrl.row_done) begin
        u <= m;
        m <= d_in;
      end
    end
    if (ctrl.load_r) begin
      r <= maj;
    end else if (ctrl.shift_r) begin
      r <= r_in;
    end
  end

  assign d_out = d;
  assign m_out = m;
  assign r_out = r;

endmodule

// ===== rtl/imtu_chain.sv =====
// Row of column cells with toroidal neighbor wiring for the active side.
// Depends on imtu_pkg and imtu_cell.
module imtu_chain
  import imtu_pkg::*;
#(
  parameter int MAX_SIDE = 64,
  parameter int SW       = $clog2(MAX_SIDE + 1)
) (
  input  logic          clk,
  input  imtu_ctrl_t    ctrl,
  input  logic [SW-1:0] side,
  input  logic          bit_in,
  output logic          bit_out
);

  logic [MAX_SIDE-1:0] d_vec;
  logic [MAX_SIDE-1:0] m_vec;
  logic [MAX_SIDE-1:0] r_vec;
  logic [MAX_SIDE-1:0] last_vec;
  logic                wrap_m;

  // Cell i holds column side-1-i once a row has streamed in; the cell with
  // last_vec set holds column zero and wraps around to cell zero.
  for (genvar i = 0; i < MAX_SIDE; i++) begin : g_last
    assign last_vec[i] = (side == SW'(i + 1));
  end

  assign wrap_m = |(m_vec & last_vec);

  for (genvar i = 0; i < MAX_SIDE; i++) begin : g_cell
    logic c_d_in;
    logic c_nb_lo;
    logic c_nb_hi;
    logic c_r_in;

    if (i == 0) begin : g_first
      assign c_d_in  = bit_in;
      assign c_nb_lo = wrap_m;
    end else begin : g_mid
      assign c_d_in  = d_vec[i-1];
      assign c_nb_lo = m_vec[i-1];
    end

    if (i == MAX_SIDE - 1) begin : g_end
      assign c_nb_hi = m_vec[0];
      assign c_r_in  = 1'b0;
    end else begin : g_inner
      assign c_nb_hi = last_vec[i] ? m_vec[0] : m_vec[i+1];
      assign c_r_in  = r_vec[i+1];
    end

    imtu_cell u_cell (
      .clk   (clk),
      .ctrl  (ctrl),
      .d_in  (c_d_in),
      .nb_lo (c_nb_lo),
      .nb_hi (c_nb_hi),
      .r_in  (c_r_in),
      .d_out (d_vec[i]),
      .m_out (m_vec[i]),
      .r_out (r_vec[i])
    );
  end

  assign bit_out = r_vec[0];

endmodule

// ===== rtl/ising_majority_torus_update_unit.sv =====
// Majority-vote Ising update unit on a square torus of one-bit spins.
// Input channel: op, cell_index, spin_in with in_valid / in_stall. Output
// channel: spin_out with out_valid / out_stall, one item per read item.
// Config channel: cfg_valid / cfg_ready with cfg_index and cfg_data; index 0
// is grid_side, index 1 is sweep_count. Write it only while the unit is idle.
// Load and read items are taken one per cycle while the unit is idle and the
// output is not backed up. A read item's spin passes through the memory read
// register, then the output register. A run item stalls the input for
// sweep_count sweeps: each sweep streams side+2 rows, one bit per cycle, through a
// row of column cells, and the last result row drains into the spare grid.
// The spin memory's single read port sets that bit rate.
// Reset selects grid A as current, sets grid_side to 64 and sweep_count to 1;
// grid contents are not cleared and no clearing pass runs.
// When the receiver stalls, one finished item waits in the output register
// and one more in the read stage; after that the input is stalled.
// Depends on imtu_pkg and imtu_chain.
module ising_majority_torus_update_unit
  import imtu_pkg::*;
#(
  parameter int MAX_SIDE = 64
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [1:0]  op,
  input  logic [11:0] cell_index,
  input  logic        spin_in,
  output logic        out_valid,
  input  logic        out_stall,
  output logic        spin_out,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic        cfg_index,
  input  logic [7:0]  cfg_data
);

  localparam int SW    = $clog2(MAX_SIDE + 1);
  localparam int DEPTH = MAX_SIDE * MAX_SIDE;
  localparam int AW    = $clog2(DEPTH);
  localparam int CW    = $clog2(DEPTH + 1);
  localparam int KW    = $clog2(MAX_SIDE + 2);
  localparam int JW    = $clog2(MAX_SIDE);

  logic [6:0]    grid_side;
  logic [7:0]    sweep_count;
  logic          cur;
  logic [7:0]    sweeps_left;

  imtu_state_t   state;
  imtu_state_t   state_next;

  logic [SW-1:0] side;
  logic [CW-1:0] cells;
  logic          accept;
  logic          in_range;
  logic [AW-1:0] item_addr;
  logic          load_fire;
  logic          read_fire;
  logic          run_fire;

  logic [KW-1:0] k;
  logic [JW-1:0] j;
  logic [AW-1:0] rd_addr;
  logic          issue;
  logic          j_end;
  logic          last_issue;
  logic          start_sweep;
  logic          drain_done;

  logic          rv;
  logic          rlast;
  logic          rgen;
  logic [SW-1:0] wcnt;
  logic [AW-1:0] w_addr;
  logic [CW-1:0] wbase;
  logic          sweep_we;
  logic          r_bit;
  imtu_ctrl_t    ctrl;

  logic          mem_a [DEPTH];
  logic          mem_b [DEPTH];
  logic          a_q;
  logic          b_q;
  logic          q;
  logic          a_we;
  logic          b_we;
  logic [AW-1:0] wa;
  logic          wd;
  logic          re;
  logic [AW-1:0] ra;

  logic          p_valid;
  logic          p_zero;
  logic          p_move;
  logic          ov;
  logic          odata;

  // Effective side, saturated to the supported range.
  always_comb begin
    if (grid_side < 7'd2) begin
      side = SW'(2);
    end else if (32'(grid_side) > MAX_SIDE) begin
      side = SW'(MAX_SIDE);
    end else begin
      side = SW'(grid_side);
    end
  end

  assign cells     = CW'(side) * CW'(side);
  assign in_range  = (32'(cell_index) < 32'(cells));
  assign item_addr = AW'(cell_index);

  assign in_stall  = (state != ST_IDLE) | (p_valid & ov & out_stall);
  assign accept    = in_valid & ~in_stall;
  assign load_fire = accept & (op == OP_LOAD) & in_range;
  assign read_fire = accept & (op == OP_READ);
  assign run_fire  = accept & (op == OP_RUN) & (sweep_count != 8'd0);

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      grid_side   <= SIDE_RESET;
      sweep_count <= SWEEP_RESET;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        CFG_GRID_SIDE:   grid_side   <= cfg_data[6:0];
        CFG_SWEEP_COUNT: sweep_count <= cfg_data;
        default:         ;
      endcase
    end
  end

  // Sequencer.
  assign j_end       = (SW'(j) == side - SW'(1));
  assign last_issue  = (state == ST_READ) & j_end & (32'(k) == 32'(side) + 1);
  assign drain_done  = (state == ST_DRAIN) & ~rv & (wcnt == '0);
  assign start_sweep = run_fire | (drain_done & (sweeps_left != 8'd1));

  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (run_fire) state_next = ST_READ;
      end
      ST_READ: begin
        if (last_issue) state_next = ST_DRAIN;
      end
      ST_DRAIN: begin
        if (drain_done) state_next = (sweeps_left == 8'd1) ? ST_IDLE : ST_READ;
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    issue = 1'b0;
    case (state)
      ST_READ:  issue = 1'b1;
      ST_IDLE:  issue = 1'b0;
      ST_DRAIN: issue = 1'b0;
      default:  issue = 1'b0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      cur   <= 1'b0;
    end else begin
      state <= state_next;
      if (drain_done) cur <= ~cur;
    end
  end

  always_ff @(posedge clk) begin
    if (run_fire) begin
      sweeps_left <= sweep_count;
    end else if (drain_done) begin
      sweeps_left <= sweeps_left - 8'd1;
    end
  end

  // Source rows stream as side-1, 0, 1, ..., side-1, 0; the flat address
  // wraps to zero at the end of the grid, which covers both wrap rows.
  always_ff @(posedge clk) begin
    if (start_sweep) begin
      k       <= '0;
      j       <= '0;
      rd_addr <= AW'(cells - CW'(side));
    end else if (issue) begin
      if (CW'(rd_addr) + CW'(1) == cells) begin
        rd_addr <= '0;
      end else begin
        rd_addr <= rd_addr + AW'(1);
      end
      if (j_end) begin
        j <= '0;
        k <= k + KW'(1);
      end else begin
        j <= j + JW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rv <= 1'b0;
    end else begin
      rv <= issue;
    end
  end

  always_ff @(posedge clk) begin
    if (issue) begin
      rlast <= j_end;
      rgen  <= (k >= KW'(2));
    end
  end

  assign ctrl.shift_en = rv;
  assign ctrl.row_done = rv & rlast;
  assign ctrl.load_r   = rv & rlast & rgen;
  assign ctrl.shift_r  = (wcnt != '0);

  imtu_chain #(
    .MAX_SIDE (MAX_SIDE),
    .SW       (SW)
  ) u_chain (
    .clk     (clk),
    .ctrl    (ctrl),
    .side    (side),
    .bit_in  (q),
    .bit_out (r_bit)
  );

  // Result rows leave the chain highest column first.
  assign sweep_we = (wcnt != '0);

  always_ff @(posedge clk) begin
    if (rst) begin
      wcnt <= '0;
    end else if (ctrl.load_r) begin
      wcnt <= side;
    end else if (sweep_we) begin
      wcnt <= wcnt - SW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (start_sweep) begin
      wbase <= '0;
    end else if (ctrl.load_r) begin
      wbase <= wbase + CW'(side);
    end
    if (ctrl.load_r) begin
      w_addr <= AW'(wbase + CW'(side) - CW'(1));
    end else if (sweep_we) begin
      w_addr <= w_addr - AW'(1);
    end
  end

  // Spin grids.
  assign a_we = (load_fire & ~cur) | (sweep_we & cur);
  assign b_we = (load_fire & cur) | (sweep_we & ~cur);
  assign wa   = load_fire ? item_addr : w_addr;
  assign wd   = load_fire ? spin_in : r_bit;
  assign re   = read_fire | issue;
  assign ra   = read_fire ? item_addr : rd_addr;

  always_ff @(posedge clk) begin
    if (a_we) mem_a[wa] <= wd;
    if (re)   a_q <= mem_a[ra];
  end

  always_ff @(posedge clk) begin
    if (b_we) mem_b[wa] <= wd;
    if (re)   b_q <= mem_b[ra];
  end

  assign q = cur ? b_q : a_q;

  // Read result path.
  assign p_move = p_valid & (~ov | ~out_stall);

  always_ff @(posedge clk) begin
    if (rst) begin
      p_valid <= 1'b0;
      ov      <= 1'b0;
    end else begin
      if (read_fire) begin
        p_valid <= 1'b1;
      end else if (p_move) begin
        p_valid <= 1'b0;
      end
      if (p_move) begin
        ov <= 1'b1;
      end else if (ov && !out_stall) begin
        ov <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (read_fire) p_zero <= ~in_range;
    if (p_move)    odata  <= p_zero ? 1'b0 : q;
  end

  assign out_valid = ov;
  assign spin_out  = odata;

endmodule
